// ===== sv/cct_pkg.sv =====
// ---------------------------------------------------------------------------
// cct_pkg
// Shared widths, item types and helpers for the circumcircle point test.
// ---------------------------------------------------------------------------
package cct_pkg;

  localparam int CW      = 32;
  localparam int TW      = 16;
  localparam int NW      = 3 * CW + 4;
  localparam int DENW    = 2 * CW + 6;
  localparam int QB      = CW + 1;
  localparam int RW      = DENW + QB + 2;
  localparam int DIV_LAT = QB + 3;
  localparam int RSQW    = 2 * CW + 4;
  localparam int SRW     = CW + 4;
  localparam int SQ_LAT  = CW + 2;
  localparam int QDEPTH  = 2;
  localparam int QAW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  typedef enum logic [3:0] {
    CASE_GEN    = 4'b0001,
    CASE_FLAT12 = 4'b0010,
    CASE_FLAT23 = 4'b0100,
    CASE_DEGEN  = 4'b1000
  } case_e;

  typedef struct packed {
    case_e                kind;
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] x3;
    logic signed [CW-1:0] y3;
    logic signed [CW:0]   dy23;
    logic signed [CW:0]   dy31;
    logic signed [CW:0]   dy12;
    logic signed [CW:0]   dx32;
    logic signed [CW:0]   dx13;
    logic signed [CW:0]   dx21;
    logic signed [CW:0]   fl0;
    logic signed [CW:0]   fr0;
    logic signed [CW:0]   fl1;
    logic signed [CW:0]   fr1;
    logic signed [CW:0]   nxf;
  } item_t;

  typedef struct packed {
    logic                 deg;
    logic signed [CW-1:0] qx;
    logic signed [CW-1:0] qy;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
  } side_t;

  typedef struct packed {
    logic                 in_circ;
    logic                 deg;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } res_side_t;

  function automatic logic signed [CW:0] sx(input logic signed [CW-1:0] a);
    return {a[CW-1], a};
  endfunction

endpackage

// ===== sv/circumcircle_incircle_test_top.sv =====
// ---------------------------------------------------------------------------
// circumcircle_incircle_test_top
// Circumcircle centre, radius and point-inside test for one triangle a beat.
// Throughput: one beat per cycle; the two centre dividers and the root unit
// are pipelined one quotient or root bit per stage and set the latency.
// busy never rises: the queue pops whenever it holds an item and never fills.
// Reset clears all valid bits and sets the tolerance register to 1.
// ---------------------------------------------------------------------------
module circumcircle_incircle_test_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          tol_we_i,
  input  logic [cct_pkg::TW-1:0]        tol_wdata_i,
  input  logic signed [cct_pkg::CW-1:0] query_x_i,
  input  logic signed [cct_pkg::CW-1:0] query_y_i,
  input  logic signed [cct_pkg::CW-1:0] first_x_i,
  input  logic signed [cct_pkg::CW-1:0] first_y_i,
  input  logic signed [cct_pkg::CW-1:0] second_x_i,
  input  logic signed [cct_pkg::CW-1:0] second_y_i,
  input  logic signed [cct_pkg::CW-1:0] third_x_i,
  input  logic signed [cct_pkg::CW-1:0] third_y_i,
  output logic                          result_valid_o,
  output logic                          inside_res_o,
  output logic                          degenerate_o,
  output logic signed [cct_pkg::CW-1:0] centre_x_o,
  output logic signed [cct_pkg::CW-1:0] centre_y_o,
  output logic [cct_pkg::CW-1:0]        radius_o
);

  logic [cct_pkg::TW-1:0] tol_q;
  logic                   q_ready, push, q_valid;
  cct_pkg::item_t         f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= cct_pkg::TW'(1);
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  cct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .tol_i      (tol_q),
    .query_x_i  (query_x_i),
    .query_y_i  (query_y_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .third_x_i  (third_x_i),
    .third_y_i  (third_y_i),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .item_o     (f_item)
  );

  cct_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cct_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .item_i         (q_item),
    .result_valid_o (result_valid_o),
    .inside_res_o   (inside_res_o),
    .degenerate_o   (degenerate_o),
    .centre_x_o     (centre_x_o),
    .centre_y_o     (centre_y_o),
    .radius_o       (radius_o)
  );

endmodule

// ===== sv/cct_front.sv =====
// ---------------------------------------------------------------------------
// cct_front
// Takes a beat, classifies the triangle and prepares edge differences.
// ---------------------------------------------------------------------------
module cct_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [cct_pkg::TW-1:0]        tol_i,
  input  logic signed [cct_pkg::CW-1:0] query_x_i,
  input  logic signed [cct_pkg::CW-1:0] query_y_i,
  input  logic signed [cct_pkg::CW-1:0] first_x_i,
  input  logic signed [cct_pkg::CW-1:0] first_y_i,
  input  logic signed [cct_pkg::CW-1:0] second_x_i,
  input  logic signed [cct_pkg::CW-1:0] second_y_i,
  input  logic signed [cct_pkg::CW-1:0] third_x_i,
  input  logic signed [cct_pkg::CW-1:0] third_y_i,
  input  logic                          q_ready_i,
  output logic                          push_o,
  output cct_pkg::item_t                item_o
);

  logic                      v_q, v_d;
  cct_pkg::item_t            it_q, it_d;
  logic signed [cct_pkg::CW:0] d21, d32;
  logic [cct_pkg::CW:0]      m21, m32, tolx;
  logic                      flat12, flat23, accept;

  assign busy   = v_q & ~q_ready_i;
  assign accept = start & ~busy;
  assign push_o = v_q & q_ready_i;
  assign item_o = it_q;

  always_comb begin
    d21    = cct_pkg::sx(second_y_i) - cct_pkg::sx(first_y_i);
    d32    = cct_pkg::sx(third_y_i) - cct_pkg::sx(second_y_i);
    m21    = d21[cct_pkg::CW] ? (~d21 + 1'b1) : d21;
    m32    = d32[cct_pkg::CW] ? (~d32 + 1'b1) : d32;
    tolx   = {{(cct_pkg::CW + 1 - cct_pkg::TW){1'b0}}, tol_i};
    flat12 = m21 < tolx;
    flat23 = m32 < tolx;

    it_d.qx   = query_x_i;
    it_d.qy   = query_y_i;
    it_d.x1   = first_x_i;
    it_d.y1   = first_y_i;
    it_d.x2   = second_x_i;
    it_d.y2   = second_y_i;
    it_d.x3   = third_x_i;
    it_d.y3   = third_y_i;
    it_d.dy23 = cct_pkg::sx(second_y_i) - cct_pkg::sx(third_y_i);
    it_d.dy31 = cct_pkg::sx(third_y_i) - cct_pkg::sx(first_y_i);
    it_d.dy12 = cct_pkg::sx(first_y_i) - cct_pkg::sx(second_y_i);
    it_d.dx32 = cct_pkg::sx(third_x_i) - cct_pkg::sx(second_x_i);
    it_d.dx13 = cct_pkg::sx(first_x_i) - cct_pkg::sx(third_x_i);
    it_d.dx21 = cct_pkg::sx(second_x_i) - cct_pkg::sx(first_x_i);

    priority if (flat12 && flat23) begin
      it_d.kind = cct_pkg::CASE_DEGEN;
    end else if (flat12) begin
      it_d.kind = cct_pkg::CASE_FLAT12;
    end else if (flat23) begin
      it_d.kind = cct_pkg::CASE_FLAT23;
    end else begin
      it_d.kind = cct_pkg::CASE_GEN;
    end

    if (flat12) begin
      it_d.fl0 = cct_pkg::sx(second_y_i) + cct_pkg::sx(third_y_i);
      it_d.fr0 = d32;
      it_d.fl1 = cct_pkg::sx(third_x_i) - cct_pkg::sx(second_x_i);
      it_d.fr1 = cct_pkg::sx(first_x_i) - cct_pkg::sx(third_x_i);
      it_d.nxf = cct_pkg::sx(first_x_i) + cct_pkg::sx(second_x_i);
    end else begin
      it_d.fl0 = cct_pkg::sx(first_y_i) + cct_pkg::sx(second_y_i);
      it_d.fr0 = d21;
      it_d.fl1 = cct_pkg::sx(second_x_i) - cct_pkg::sx(first_x_i);
      it_d.fr1 = cct_pkg::sx(third_x_i) - cct_pkg::sx(first_x_i);
      it_d.nxf = cct_pkg::sx(third_x_i) + cct_pkg::sx(second_x_i);
    end
  end

  always_comb begin
    priority if (accept) begin
      v_d = 1'b1;
    end else if (push_o) begin
      v_d = 1'b0;
    end else begin
      v_d = v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      it_q <= it_d;
    end
  end

endmodule

// ===== sv/cct_queue.sv =====
// ---------------------------------------------------------------------------
// cct_queue
// Short queue between the classifier and the arithmetic pipeline.
// ---------------------------------------------------------------------------
module cct_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cct_pkg::item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  output cct_pkg::item_t item_o
);

  cct_pkg::item_t              mem_q [cct_pkg::QDEPTH];
  logic [cct_pkg::QAW-1:0]     wp_q, rp_q;
  logic [cct_pkg::QCW-1:0]     cnt_q, cnt_d;
  logic                        pop, push;

  assign pop     = cnt_q != '0;
  assign valid_o = pop;
  assign ready_o = (cnt_q != cct_pkg::QCW'(cct_pkg::QDEPTH)) | pop;
  assign push    = push_i & ready_o;
  assign item_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= (wp_q == cct_pkg::QAW'(cct_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= (rp_q == cct_pkg::QAW'(cct_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= item_i;
    end
  end

endmodule

// ===== sv/cct_div.sv =====
// ---------------------------------------------------------------------------
// cct_div
// Pipelined rounding divider, one quotient bit per stage, saturated result.
// ---------------------------------------------------------------------------
module cct_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [cct_pkg::NW-1:0]   num_i,
  input  logic signed [cct_pkg::DENW-1:0] den_i,
  output logic                            valid_o,
  output logic signed [cct_pkg::CW-1:0]   quo_o,
  output logic                            zero_o
);

  localparam int QB  = cct_pkg::QB;
  localparam int RW  = cct_pkg::RW;
  localparam int DRW = cct_pkg::DENW + 1;
  localparam int L   = QB + 1;
  localparam logic [QB-1:0] MAXM = {{(QB - cct_pkg::CW + 1){1'b0}}, {(cct_pkg::CW - 1){1'b1}}};
  localparam logic [QB-1:0] MINM = {{(QB - cct_pkg::CW){1'b0}}, 1'b1, {(cct_pkg::CW - 1){1'b0}}};
  localparam logic [cct_pkg::CW-1:0] SMAX = {1'b0, {(cct_pkg::CW - 1){1'b1}}};
  localparam logic [cct_pkg::CW-1:0] SMIN = {1'b1, {(cct_pkg::CW - 1){1'b0}}};

  logic            v_q    [L+1];
  logic [RW-1:0]   rem_q  [L+1];
  logic [DRW-1:0]  den_q  [L+1];
  logic [QB-1:0]   q_q    [L+1];
  logic            ovf_q  [L+1];
  logic            flip_q [L+1];
  logic            zero_q [L+1];

  logic [cct_pkg::NW-1:0]   an;
  logic [cct_pkg::DENW-1:0] ad;
  logic [cct_pkg::CW-1:0]   qo_d, qo_q;
  logic                     vo_q, zo_q;

  always_comb begin
    an = num_i[cct_pkg::NW-1] ? cct_pkg::NW'(-num_i) : cct_pkg::NW'(num_i);
    ad = den_i[cct_pkg::DENW-1] ? cct_pkg::DENW'(-den_i) : cct_pkg::DENW'(den_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RW'({an, 1'b0}) + RW'(ad);
    den_q[0]  <= {ad, 1'b0};
    q_q[0]    <= '0;
    ovf_q[0]  <= 1'b0;
    flip_q[0] <= num_i[cct_pkg::NW-1] ^ den_i[cct_pkg::DENW-1];
    zero_q[0] <= ad == '0;
  end

  for (genvar s = 1; s <= L; s++) begin : g_st
    localparam int K = L - s;
    logic [RW-1:0] sub;
    logic          ge;

    assign sub = RW'(den_q[s-1]) << K;
    assign ge  = rem_q[s-1] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= ge ? rem_q[s-1] - sub : rem_q[s-1];
      den_q[s]  <= den_q[s-1];
      q_q[s]    <= (K < QB && ge) ? (q_q[s-1] | (QB'(1) << K)) : q_q[s-1];
      ovf_q[s]  <= ovf_q[s-1] | (K == QB && ge);
      flip_q[s] <= flip_q[s-1];
      zero_q[s] <= zero_q[s-1];
    end
  end

  always_comb begin
    priority if (zero_q[L]) begin
      qo_d = '0;
    end else if (ovf_q[L]) begin
      qo_d = flip_q[L] ? SMIN : SMAX;
    end else if (!flip_q[L]) begin
      qo_d = (q_q[L] > MAXM) ? SMAX : q_q[L][cct_pkg::CW-1:0];
    end else begin
      qo_d = (q_q[L] > MINM) ? SMIN : (~q_q[L][cct_pkg::CW-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    qo_q <= qo_d;
    zo_q <= zero_q[L];
  end

  assign valid_o = vo_q;
  assign quo_o   = qo_q;
  assign zero_o  = zo_q;

endmodule

// ===== sv/cct_sqrt.sv =====
// ---------------------------------------------------------------------------
// cct_sqrt
// Pipelined integer square root, one result bit per stage, clamped.
// ---------------------------------------------------------------------------
module cct_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [cct_pkg::RSQW-1:0]  rad_i,
  output logic                      valid_o,
  output logic [cct_pkg::CW-1:0]    root_o
);

  localparam int CW  = cct_pkg::CW;
  localparam int SRW = cct_pkg::SRW;

  logic            v_q    [CW+1];
  logic [2*CW-1:0] rad_q  [CW+1];
  logic [SRW-1:0]  rem_q  [CW+1];
  logic [CW-1:0]   root_q [CW+1];
  logic            clp_q  [CW+1];
  logic            vo_q;
  logic [CW-1:0]   ro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= rad_i[2*CW-1:0];
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    clp_q[0]  <= |rad_i[cct_pkg::RSQW-1:2*CW];
  end

  for (genvar s = 1; s <= CW; s++) begin : g_st
    logic [SRW-1:0] cur, trial;
    logic           ge;

    assign cur   = {rem_q[s-1][SRW-3:0], rad_q[s-1][2*CW-1 -: 2]};
    assign trial = SRW'({root_q[s-1], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_q[s-1] << 2;
      rem_q[s]  <= ge ? cur - trial : cur;
      root_q[s] <= {root_q[s-1][CW-2:0], ge};
      clp_q[s]  <= clp_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    ro_q <= clp_q[CW] ? '1 : root_q[CW];
  end

  assign valid_o = vo_q;
  assign root_o  = ro_q;

endmodule

// ===== sv/cct_back.sv =====
// ---------------------------------------------------------------------------
// cct_back
// Arithmetic pipeline: numerators, centre division, radius and inside test.
// ---------------------------------------------------------------------------
module cct_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  cct_pkg::item_t                item_i,
  output logic                          result_valid_o,
  output logic                          inside_res_o,
  output logic                          degenerate_o,
  output logic signed [cct_pkg::CW-1:0] centre_x_o,
  output logic signed [cct_pkg::CW-1:0] centre_y_o,
  output logic [cct_pkg::CW-1:0]        radius_o
);

  localparam int CW = cct_pkg::CW;

  // product stage
  logic                    v1_q;
  cct_pkg::item_t          it1_q;
  logic signed [2*CW-1:0]  sq1_q [6];
  logic signed [2*CW:0]    dt1_q [3];
  logic signed [2*CW+1:0]  pa1_q, pb1_q;

  // square sums
  logic                          v2_q;
  cct_pkg::item_t                it2_q;
  logic [2*CW-1:0]               s2_q [3];
  logic signed [cct_pkg::DENW-1:0] dd2_q;
  logic signed [2*CW+2:0]        nyf2_q;

  // partial products
  logic                          v3_q;
  cct_pkg::item_t                it3_q;
  logic signed [2*CW+1:0]        plo3_q [6];
  logic signed [2*CW+1:0]        phi3_q [6];
  logic signed [cct_pkg::DENW-1:0] dd3_q;
  logic signed [2*CW+2:0]        nyf3_q;
  logic signed [CW:0]            df [6];

  // term assembly
  logic                          v4_q;
  cct_pkg::item_t                it4_q;
  logic signed [cct_pkg::NW-1:0] tm4_q [6];
  logic signed [cct_pkg::DENW-1:0] dd4_q;
  logic signed [2*CW+2:0]        nyf4_q;

  // divider operands
  logic                            v5_q;
  logic signed [cct_pkg::NW-1:0]   nx5_q, ny5_q, nx5_d, ny5_d;
  logic signed [cct_pkg::DENW-1:0] dx5_q, dy5_q, dx5_d, dy5_d;
  cct_pkg::side_t                  sd5_q;

  cct_pkg::side_t      dl1_q  [cct_pkg::DIV_LAT];
  logic                dl1v_q [cct_pkg::DIV_LAT];

  logic                dvx_valid, dvy_valid, zx, zy;
  logic signed [CW-1:0] cx, cy;

  // distance stages
  logic                vE_q, degE_q;
  logic signed [CW:0]  ex_q, ey_q, fx_q, fy_q;
  logic signed [CW-1:0] cxE_q, cyE_q;
  logic                vM_q, degM_q;
  logic signed [2*CW+1:0] e2_q [4];
  logic signed [CW-1:0] cxM_q, cyM_q;
  logic                vS_q;
  logic [cct_pkg::RSQW-1:0] rsq_q, rsq_d, dsq_d;
  cct_pkg::res_side_t  rsS_q;

  cct_pkg::res_side_t  dl2_q  [cct_pkg::SQ_LAT];
  logic                dl2v_q [cct_pkg::SQ_LAT];

  logic                sq_valid;
  logic [CW-1:0]       root;

  logic                res_v_q, res_in_q, res_deg_q;
  logic signed [CW-1:0] res_cx_q, res_cy_q;
  logic [CW-1:0]       res_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vE_q <= 1'b0;
      vM_q <= 1'b0;
      vS_q <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vE_q <= dvx_valid;
      vM_q <= vE_q;
      vS_q <= vM_q;
      res_v_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    it1_q    <= item_i;
    sq1_q[0] <= item_i.x1 * item_i.x1;
    sq1_q[1] <= item_i.y1 * item_i.y1;
    sq1_q[2] <= item_i.x2 * item_i.x2;
    sq1_q[3] <= item_i.y2 * item_i.y2;
    sq1_q[4] <= item_i.x3 * item_i.x3;
    sq1_q[5] <= item_i.y3 * item_i.y3;
    dt1_q[0] <= item_i.x1 * item_i.dy23;
    dt1_q[1] <= item_i.x2 * item_i.dy31;
    dt1_q[2] <= item_i.x3 * item_i.dy12;
    pa1_q    <= item_i.fl0 * item_i.fr0;
    pb1_q    <= item_i.fl1 * item_i.fr1;
  end

  always_ff @(posedge clk_i) begin
    it2_q <= it1_q;
    for (int i = 0; i < 3; i++) begin
      s2_q[i] <= $unsigned(sq1_q[2*i]) + $unsigned(sq1_q[2*i+1]);
    end
    dd2_q  <= (dt1_q[0] + dt1_q[1] + dt1_q[2]) <<< 1;
    nyf2_q <= pa1_q - pb1_q;
  end

  always_comb begin
    df[0] = it2_q.dy23;
    df[1] = it2_q.dy31;
    df[2] = it2_q.dy12;
    df[3] = it2_q.dx32;
    df[4] = it2_q.dx13;
    df[5] = it2_q.dx21;
  end

  always_ff @(posedge clk_i) begin
    it3_q  <= it2_q;
    dd3_q  <= dd2_q;
    nyf3_q <= nyf2_q;
    for (int j = 0; j < 6; j++) begin
      plo3_q[j] <= $signed({1'b0, s2_q[j % 3][CW-1:0]}) * df[j];
      phi3_q[j] <= $signed({1'b0, s2_q[j % 3][2*CW-1:CW]}) * df[j];
    end
  end

  always_ff @(posedge clk_i) begin
    it4_q  <= it3_q;
    dd4_q  <= dd3_q;
    nyf4_q <= nyf3_q;
    for (int j = 0; j < 6; j++) begin
      tm4_q[j] <= (cct_pkg::NW'(phi3_q[j]) <<< CW) + cct_pkg::NW'(plo3_q[j]);
    end
  end

  always_comb begin
    unique case (it4_q.kind)
      cct_pkg::CASE_GEN: begin
        nx5_d = tm4_q[0] + tm4_q[1] + tm4_q[2];
        ny5_d = tm4_q[3] + tm4_q[4] + tm4_q[5];
        dx5_d = dd4_q;
        dy5_d = dd4_q;
      end
      cct_pkg::CASE_FLAT12, cct_pkg::CASE_FLAT23, cct_pkg::CASE_DEGEN: begin
        nx5_d = cct_pkg::NW'(it4_q.nxf);
        ny5_d = cct_pkg::NW'(nyf4_q);
        dx5_d = cct_pkg::DENW'(2);
        dy5_d = cct_pkg::DENW'(it4_q.fr0) <<< 1;
      end
      default: begin
        nx5_d = tm4_q[0] + tm4_q[1] + tm4_q[2];
        ny5_d = tm4_q[3] + tm4_q[4] + tm4_q[5];
        dx5_d = dd4_q;
        dy5_d = dd4_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    nx5_q     <= nx5_d;
    ny5_q     <= ny5_d;
    dx5_q     <= dx5_d;
    dy5_q     <= dy5_d;
    sd5_q.deg <= it4_q.kind == cct_pkg::CASE_DEGEN;
    sd5_q.qx  <= it4_q.qx;
    sd5_q.qy  <= it4_q.qy;
    sd5_q.x2  <= it4_q.x2;
    sd5_q.y2  <= it4_q.y2;
  end

  cct_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (nx5_q),
    .den_i   (dx5_q),
    .valid_o (dvx_valid),
    .quo_o   (cx),
    .zero_o  (zx)
  );

  cct_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (ny5_q),
    .den_i   (dy5_q),
    .valid_o (dvy_valid),
    .quo_o   (cy),
    .zero_o  (zy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cct_pkg::DIV_LAT; i++) begin
        dl1v_q[i] <= 1'b0;
      end
      for (int i = 0; i < cct_pkg::SQ_LAT; i++) begin
        dl2v_q[i] <= 1'b0;
      end
    end else begin
      dl1v_q[0] <= v5_q;
      for (int i = 1; i < cct_pkg::DIV_LAT; i++) begin
        dl1v_q[i] <= dl1v_q[i-1];
      end
      dl2v_q[0] <= vS_q;
      for (int i = 1; i < cct_pkg::SQ_LAT; i++) begin
        dl2v_q[i] <= dl2v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dl1_q[0] <= sd5_q;
    for (int i = 1; i < cct_pkg::DIV_LAT; i++) begin
      dl1_q[i] <= dl1_q[i-1];
    end
    dl2_q[0] <= rsS_q;
    for (int i = 1; i < cct_pkg::SQ_LAT; i++) begin
      dl2_q[i] <= dl2_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ex_q   <= cct_pkg::sx(dl1_q[cct_pkg::DIV_LAT-1].x2) - cct_pkg::sx(cx);
    ey_q   <= cct_pkg::sx(dl1_q[cct_pkg::DIV_LAT-1].y2) - cct_pkg::sx(cy);
    fx_q   <= cct_pkg::sx(dl1_q[cct_pkg::DIV_LAT-1].qx) - cct_pkg::sx(cx);
    fy_q   <= cct_pkg::sx(dl1_q[cct_pkg::DIV_LAT-1].qy) - cct_pkg::sx(cy);
    degE_q <= dl1_q[cct_pkg::DIV_LAT-1].deg | zx | zy;
    cxE_q  <= cx;
    cyE_q  <= cy;
  end

  always_ff @(posedge clk_i) begin
    e2_q[0] <= ex_q * ex_q;
    e2_q[1] <= ey_q * ey_q;
    e2_q[2] <= fx_q * fx_q;
    e2_q[3] <= fy_q * fy_q;
    degM_q  <= degE_q;
    cxM_q   <= cxE_q;
    cyM_q   <= cyE_q;
  end

  always_comb begin
    rsq_d = $unsigned(cct_pkg::RSQW'(e2_q[0])) + $unsigned(cct_pkg::RSQW'(e2_q[1]));
    dsq_d = $unsigned(cct_pkg::RSQW'(e2_q[2])) + $unsigned(cct_pkg::RSQW'(e2_q[3]));
  end

  always_ff @(posedge clk_i) begin
    rsq_q         <= rsq_d;
    rsS_q.in_circ <= dsq_d <= rsq_d;
    rsS_q.deg     <= degM_q;
    rsS_q.cx      <= cxM_q;
    rsS_q.cy      <= cyM_q;
  end

  cct_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vS_q),
    .rad_i   (rsq_q),
    .valid_o (sq_valid),
    .root_o  (root)
  );

  always_ff @(posedge clk_i) begin
    res_deg_q <= dl2_q[cct_pkg::SQ_LAT-1].deg;
    if (dl2_q[cct_pkg::SQ_LAT-1].deg) begin
      res_in_q <= 1'b0;
      res_cx_q <= '0;
      res_cy_q <= '0;
      res_r_q  <= '0;
    end else begin
      res_in_q <= dl2_q[cct_pkg::SQ_LAT-1].in_circ;
      res_cx_q <= dl2_q[cct_pkg::SQ_LAT-1].cx;
      res_cy_q <= dl2_q[cct_pkg::SQ_LAT-1].cy;
      res_r_q  <= root;
    end
  end

  assign result_valid_o = res_v_q;
  assign inside_res_o   = res_in_q;
  assign degenerate_o   = res_deg_q;
  assign centre_x_o     = res_cx_q;
  assign centre_y_o     = res_cy_q;
  assign radius_o       = res_r_q;

  a_div_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx_valid == dl1v_q[cct_pkg::DIV_LAT-1])
    else $error("divider output out of step with side data");

  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dvx_valid == dvy_valid)
    else $error("centre dividers out of step");

  a_sqrt_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid == dl2v_q[cct_pkg::SQ_LAT-1])
    else $error("root output out of step with side data");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_v_q && res_deg_q |->
      !res_in_q && res_cx_q == '0 && res_cy_q == '0 && res_r_q == '0)
    else $error("degenerate beat with nonzero fields");

endmodule

// ===== tb/tb_circumcircle_incircle_test_top.sv =====
// ---------------------------------------------------------------------------
// tb_circumcircle_incircle_test_top
// Self-checking bench for the circumcircle point test. A predictor computes
// the centre, radius, inside flag and degenerate flag of every accepted beat
// with wide exact integers, and a checker compares each strobed result with
// the oldest prediction. Directed triangles cover the edge cases, then random
// triangles run under several tolerance settings and sender idle rates.
// ---------------------------------------------------------------------------
module tb_circumcircle_incircle_test_top;

  typedef logic signed [255:0] big_t;
  typedef logic signed [cct_pkg::CW-1:0] coord_t;

  typedef struct packed {
    logic                   in_circ;
    logic                   deg;
    coord_t                 cx;
    coord_t                 cy;
    logic [cct_pkg::CW-1:0] radius;
  } circle_t;

  localparam int DRAIN_CYCLES = 100;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   tol_we_i;
  logic [cct_pkg::TW-1:0] tol_wdata_i;
  coord_t                 query_x_i, query_y_i, first_x_i, first_y_i;
  coord_t                 second_x_i, second_y_i, third_x_i, third_y_i;
  logic                   result_valid_o;
  logic                   inside_res_o;
  logic                   degenerate_o;
  coord_t                 centre_x_o, centre_y_o;
  logic [cct_pkg::CW-1:0] radius_o;

  circle_t                pending_circles[$];
  logic [cct_pkg::TW-1:0] tol_model;
  int                     errors;
  int                     gap_pct;

  circumcircle_incircle_test_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .tol_we_i       (tol_we_i),
    .tol_wdata_i    (tol_wdata_i),
    .query_x_i      (query_x_i),
    .query_y_i      (query_y_i),
    .first_x_i      (first_x_i),
    .first_y_i      (first_y_i),
    .second_x_i     (second_x_i),
    .second_y_i     (second_y_i),
    .third_x_i      (third_x_i),
    .third_y_i      (third_y_i),
    .result_valid_o (result_valid_o),
    .inside_res_o   (inside_res_o),
    .degenerate_o   (degenerate_o),
    .centre_x_o     (centre_x_o),
    .centre_y_o     (centre_y_o),
    .radius_o       (radius_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic big_t abs_big(input big_t v);
    return (v < 0) ? -v : v;
  endfunction

  // nearest quotient, halves away from zero
  function automatic big_t round_quotient(input big_t n, input big_t d);
    big_t an, ad, q;
    an = abs_big(n);
    ad = abs_big(d);
    q = (2 * an + ad) / (2 * ad);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic coord_t clamp_coord(input big_t v);
    big_t hi, lo;
    hi = (big_t'(1) <<< (cct_pkg::CW - 1)) - 1;
    lo = -(big_t'(1) <<< (cct_pkg::CW - 1));
    if (v > hi) return coord_t'(hi[cct_pkg::CW-1:0]);
    if (v < lo) return coord_t'(lo[cct_pkg::CW-1:0]);
    return coord_t'(v[cct_pkg::CW-1:0]);
  endfunction

  function automatic circle_t predict_circle(input coord_t qx, qy, x1, y1, x2, y2, x3, y3,
                                             input logic [cct_pkg::TW-1:0] tol);
    circle_t res;
    big_t bqx, bqy, bx1, by1, bx2, by2, bx3, by3, btol;
    big_t nx, dx, ny, dy, s1, s2, s3, dd, cxw, cyw, ex, ey, rsq, dsq, rr, tt;
    coord_t cx, cy;
    logic flat12, flat23;
    res = '0;
    res.deg = 1'b1;
    bqx = qx; bqy = qy; bx1 = x1; by1 = y1;
    bx2 = x2; by2 = y2; bx3 = x3; by3 = y3;
    btol = '0;
    btol[cct_pkg::TW-1:0] = tol;
    flat12 = abs_big(by2 - by1) < btol;
    flat23 = abs_big(by3 - by2) < btol;
    if (flat12 && flat23) return res;
    if (flat12) begin
      nx = bx1 + bx2;
      dx = 2;
      ny = (by2 + by3) * (by3 - by2) - (bx3 - bx2) * (bx1 - bx3);
      dy = 2 * (by3 - by2);
    end else if (flat23) begin
      nx = bx3 + bx2;
      dx = 2;
      ny = (by1 + by2) * (by2 - by1) - (bx2 - bx1) * (bx3 - bx1);
      dy = 2 * (by2 - by1);
    end else begin
      s1 = bx1 * bx1 + by1 * by1;
      s2 = bx2 * bx2 + by2 * by2;
      s3 = bx3 * bx3 + by3 * by3;
      dd = bx1 * (by2 - by3) + bx2 * (by3 - by1) + bx3 * (by1 - by2);
      dx = 2 * dd;
      dy = dx;
      nx = s1 * (by2 - by3) + s2 * (by3 - by1) + s3 * (by1 - by2);
      ny = s1 * (bx3 - bx2) + s2 * (bx1 - bx3) + s3 * (bx2 - bx1);
    end
    if (dx == 0 || dy == 0) return res;
    cxw = round_quotient(nx, dx);
    cyw = round_quotient(ny, dy);
    cx = clamp_coord(cxw);
    cy = clamp_coord(cyw);
    ex = bx2 - big_t'(cx);
    ey = by2 - big_t'(cy);
    rsq = ex * ex + ey * ey;
    rr = 0;
    for (int k = cct_pkg::CW + 1; k >= 0; k--) begin
      tt = rr;
      tt[k] = 1'b1;
      if (tt * tt <= rsq) rr = tt;
    end
    if (rr > (big_t'(1) <<< cct_pkg::CW) - 1) rr = (big_t'(1) <<< cct_pkg::CW) - 1;
    ex = bqx - big_t'(cx);
    ey = bqy - big_t'(cy);
    dsq = ex * ex + ey * ey;
    res.in_circ = dsq <= rsq;
    res.deg = 1'b0;
    res.cx = cx;
    res.cy = cy;
    res.radius = rr[cct_pkg::CW-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin
    circle_t exp_c;
    if (rst_ni && result_valid_o) begin
      if (pending_circles.size() == 0) begin
        $display("%0t: result beat with no prediction pending", $time);
        errors++;
      end else begin
        exp_c = pending_circles.pop_front();
        if (inside_res_o !== exp_c.in_circ) begin
          $display("%0t: inside_res exp %0b got %0b", $time, exp_c.in_circ, inside_res_o);
          errors++;
        end
        if (degenerate_o !== exp_c.deg) begin
          $display("%0t: degenerate exp %0b got %0b", $time, exp_c.deg, degenerate_o);
          errors++;
        end
        if (centre_x_o !== exp_c.cx) begin
          $display("%0t: centre_x exp %0d got %0d", $time, exp_c.cx, centre_x_o);
          errors++;
        end
        if (centre_y_o !== exp_c.cy) begin
          $display("%0t: centre_y exp %0d got %0d", $time, exp_c.cy, centre_y_o);
          errors++;
        end
        if (radius_o !== exp_c.radius) begin
          $display("%0t: radius exp %0d got %0d", $time, exp_c.radius, radius_o);
          errors++;
        end
      end
    end
  end

  task automatic send_triangle(input coord_t qx, qy, x1, y1, x2, y2, x3, y3);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    query_x_i <= qx; query_y_i <= qy;
    first_x_i <= x1; first_y_i <= y1;
    second_x_i <= x2; second_y_i <= y2;
    third_x_i <= x3; third_y_i <= y3;
    do @(posedge clk_i); while (busy);
    pending_circles.insert(pending_circles.size(),
                           predict_circle(qx, qy, x1, y1, x2, y2, x3, y3, tol_model));
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    end_burst();
    while (pending_circles.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [cct_pkg::TW-1:0] value);
    wait_drained();
    @(negedge clk_i);
    tol_we_i <= 1'b1;
    tol_wdata_i <= value;
    @(negedge clk_i);
    tol_we_i <= 1'b0;
    tol_model = value;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return coord_t'($signed($urandom_range(200000)) - 100000);
      default: return coord_t'($signed($urandom_range(60)) - 30);
    endcase
  endfunction

  task automatic send_random_triangle();
    coord_t qx, qy, x1, y1, x2, y2, x3, y3, off;
    int mode;
    qx = rand_coord(); qy = rand_coord();
    x1 = rand_coord(); y1 = rand_coord();
    x2 = rand_coord(); y2 = rand_coord();
    x3 = rand_coord(); y3 = rand_coord();
    off = coord_t'($signed($urandom_range(8)) - 4);
    mode = $urandom_range(9);
    case (mode)
      0: y2 = y1 + off;
      1: y3 = y2 + off;
      2: begin
        y2 = y1 + off;
        y3 = y2 - off;
      end
      3: begin
        x3 = x2 + (x2 - x1);
        y3 = y2 + (y2 - y1);
      end
      4: begin
        qx = x2;
        qy = y2;
      end
      5: begin
        qx = x1 + off;
        qy = y1 - off;
      end
      default: ;
    endcase
    send_triangle(qx, qy, x1, y1, x2, y2, x3, y3);
  endtask

  task automatic test_default_tolerance();
    send_triangle(0, 0, 0, 0, 10, 0, 0, 10);
    send_triangle(5, 5, -65536, 0, 65536, 0, 0, 65536);
    send_triangle(0, 0, 7, 3, -2, 3, 11, 3);
    send_triangle(1, 1, 0, 0, 1, 1, 2, 2);
    send_triangle(3, 4, 0, 0, 6, 0, 3, 9);
    send_triangle(0, 0, 0, 0, 1, 0, 0, 1);
    send_triangle(100, 100, 0, 5, 4, 0, 8, 5);
  endtask

  task automatic test_extreme_coordinates();
    coord_t mx, mn;
    mx = coord_t'(32'h7fff_ffff);
    mn = coord_t'(32'h8000_0000);
    send_triangle(mx, mx, mn, mn, mx, mn, mn, mx);
    send_triangle(mn, mn, mx, mx, mn, mx, mx, mn);
    send_triangle(mx, mn, mx, 0, mn, 1, 0, mx);
    send_triangle(0, 0, mx, mx - 1, mx - 1, mn, mn + 1, mx);
    send_triangle(mn, mx, 0, 0, mx, 1, 1, mn);
    send_triangle(-1, -1, -1, -1, -1, -1, -1, -1);
    send_triangle(mx, mx, 1, 2, -3, mx, mx, mn);
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance('0);
    send_triangle(0, 0, 0, 0, 10, 0, 0, 10);
    send_triangle(0, 0, 5, 7, 9, 7, 12, 7);
    send_triangle(1, 2, 3, 0, 3, 8, 3, 8);
    write_tolerance('1);
    send_triangle(0, 0, 0, 0, 10, 100, 0, 65534);
    send_triangle(0, 0, 0, 0, 10, 65535, 20, 70000);
    send_triangle(9, 9, 0, 200000, 10, 0, 20, 65534);
    send_triangle(0, 0, 0, 0, 10, 65534, 20, 131068);
    write_tolerance(16'd1);
  endtask

  task automatic test_random_phase(input logic [cct_pkg::TW-1:0] tol, input int pct,
                                   input int count);
    write_tolerance(tol);
    gap_pct = pct;
    for (int i = 0; i < count; i++) send_random_triangle();
    gap_pct = 0;
  endtask

  task automatic test_pause_until_drained();
    for (int i = 0; i < 20; i++) send_random_triangle();
    wait_drained();
    for (int i = 0; i < 20; i++) send_random_triangle();
  endtask

  initial begin
    int waited;
    errors = 0;
    gap_pct = 0;
    tol_model = 16'd1;
    rst_ni = 1'b0;
    start = 1'b0;
    tol_we_i = 1'b0;
    tol_wdata_i = '0;
    query_x_i = '0; query_y_i = '0;
    first_x_i = '0; first_y_i = '0;
    second_x_i = '0; second_y_i = '0;
    third_x_i = '0; third_y_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_tolerance();
    test_extreme_coordinates();
    test_tolerance_extremes();
    test_random_phase(16'd1, 0, 320);
    test_random_phase(16'd0, 47, 320);
    test_random_phase(16'd5, 29, 320);
    test_random_phase(16'hffff, 47, 150);
    test_random_phase(16'd3, 0, 200);
    test_pause_until_drained();

    end_burst();
    waited = 0;
    while (pending_circles.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_circles.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== circumcircle_incircle_test_top.f =====
sv/cct_pkg.sv
sv/cct_front.sv
sv/cct_queue.sv
sv/cct_div.sv
sv/cct_sqrt.sv
sv/cct_back.sv
sv/circumcircle_incircle_test_top.sv
tb/tb_circumcircle_incircle_test_top.sv
